// File: src/itp_pkg.sv
// Shared types, codes and constants of the ISO-TP receive reassembler.
package itp_pkg;

	localparam int MAX_MESSAGE_BYTES = 4095;
	localparam int CMD_DEPTH         = 4;

	localparam int LEN_W   = 12;
	localparam int TIMER_W = 16;
	localparam int ID_W    = 29;
	localparam int CFG_W   = 29;
	localparam int IDX_W   = 3;

	// Upper nibble of the PCI byte.
	localparam logic [3:0] PCI_SINGLE = 4'h0;
	localparam logic [3:0] PCI_FIRST  = 4'h1;
	localparam logic [3:0] PCI_CONSEC = 4'h2;
	localparam logic [7:0] FC_PCI     = 8'h30;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_FC   = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	localparam logic [2:0] ERR_NONE    = 3'd0;
	localparam logic [2:0] ERR_SF_LEN  = 3'd1;
	localparam logic [2:0] ERR_FF_LEN  = 3'd2;
	localparam logic [2:0] ERR_PCI     = 3'd3;
	localparam logic [2:0] ERR_SEQ     = 3'd4;
	localparam logic [2:0] ERR_TIMEOUT = 3'd5;

	localparam logic [IDX_W-1:0] REG_RECEIVE_ID    = 3'd0;
	localparam logic [IDX_W-1:0] REG_FC_BLOCK_SIZE = 3'd1;
	localparam logic [IDX_W-1:0] REG_FC_SEP_TIME   = 3'd2;
	localparam logic [IDX_W-1:0] REG_TIMEOUT_LIMIT = 3'd3;
	localparam logic [IDX_W-1:0] REG_PADDING_EN    = 3'd4;
	localparam logic [IDX_W-1:0] REG_PADDING_VALUE = 3'd5;

	localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 16'd1000;
	localparam logic [7:0]         PADDING_RESET = 8'hCC;

	localparam logic [3:0] FC_LEN_PADDED   = 4'd8;
	localparam logic [3:0] FC_LEN_UNPADDED = 4'd3;
	localparam logic [3:0] FF_DATA_BYTES   = 4'd6;

	typedef struct packed {
		logic [ID_W-1:0]    receive_id;
		logic [7:0]         block_size;
		logic [7:0]         fc_separation_time;
		logic [TIMER_W-1:0] timeout_limit_ms;
		logic               padding_enable;
		logic [7:0]         padding_value;
	} itp_cfg_t;

	typedef enum logic [1:0] {
		CMD_DATA,
		CMD_FF,
		CMD_ERR
	} cmd_op_t;

	// One queued job for the back end: a run of payload bytes, a first
	// frame with its flow control reply, or an error word.
	typedef struct packed {
		cmd_op_t        op;
		logic [6:0][7:0] data;
		logic [2:0]     ndata;
		logic           data_last;
		logic [2:0]     err;
	} itp_cmd_t;

endpackage

// File: src/itp_front.sv
// Front end: frame filtering, PCI decoding and reassembly state.
module itp_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  itp_pkg::itp_cfg_t     cfg,
	input  logic                  push,
	input  logic                  q_full,
	input  logic                  mode,
	input  logic [28:0]           frame_id,
	input  logic [7:0][7:0]       frame_bytes,
	output logic                  cmd_push,
	output itp_pkg::itp_cmd_t     cmd
);
	import itp_pkg::*;

	logic               reassembling_q, reassembling_n;
	logic [LEN_W-1:0]   total_q, total_n;
	logic [LEN_W-1:0]   received_q, received_n;
	logic [3:0]         seq_q, seq_n;
	logic [TIMER_W-1:0] elapsed_q, elapsed_n;

	logic               accept;
	logic [3:0]         pci;
	logic [3:0]         low;
	logic [TIMER_W-1:0] elapsed_inc;
	logic [LEN_W-1:0]   remaining;
	logic [LEN_W-1:0]   ff_total;
	logic               result;

	assign accept = push && !q_full;
	assign pci    = frame_bytes[0][7:4];
	assign low    = frame_bytes[0][3:0];
	assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 1'b1;
	assign remaining   = total_q - received_q;
	assign ff_total    = {low, frame_bytes[1]};

	always_comb begin
		reassembling_n = reassembling_q;
		total_n        = total_q;
		received_n     = received_q;
		seq_n          = seq_q;
		elapsed_n      = elapsed_q;
		result         = 1'b0;
		cmd            = '0;
		cmd.op         = CMD_DATA;
		for (int i = 0; i < 7; i++) begin
			cmd.data[i] = frame_bytes[i+1];
		end

		if (mode) begin
			if (reassembling_q) begin
				elapsed_n = elapsed_inc;
				if (elapsed_inc >= cfg.timeout_limit_ms) begin
					result  = 1'b1;
					cmd.op  = CMD_ERR;
					cmd.err = ERR_TIMEOUT;
				end
			end
		end else if (frame_id == cfg.receive_id) begin
			if (reassembling_q) begin
				if (elapsed_q >= cfg.timeout_limit_ms) begin
					result  = 1'b1;
					cmd.op  = CMD_ERR;
					cmd.err = ERR_TIMEOUT;
				end else if (pci == PCI_CONSEC) begin
					result = 1'b1;
					if (low != seq_q) begin
						cmd.op  = CMD_ERR;
						cmd.err = ERR_SEQ;
					end else begin
						cmd.ndata     = (remaining >= LEN_W'(7)) ? 3'd7 : remaining[2:0];
						cmd.data_last = (remaining <= LEN_W'(7));
						received_n    = received_q + LEN_W'(cmd.ndata);
						seq_n         = seq_q + 1'b1;
					end
				end
			end else begin
				result = 1'b1;
				case (pci)
					PCI_SINGLE: begin
						if (low == 4'd0 || low > 4'd7) begin
							cmd.op  = CMD_ERR;
							cmd.err = ERR_SF_LEN;
						end else begin
							cmd.ndata     = low[2:0];
							cmd.data_last = 1'b1;
						end
					end
					PCI_FIRST: begin
						if (ff_total < LEN_W'(8) || ff_total > LEN_W'(MAX_MESSAGE_BYTES)) begin
							cmd.op  = CMD_ERR;
							cmd.err = ERR_FF_LEN;
						end else begin
							cmd.op    = CMD_FF;
							cmd.ndata = FF_DATA_BYTES[2:0];
							for (int i = 0; i < 6; i++) begin
								cmd.data[i] = frame_bytes[i+2];
							end
							reassembling_n = 1'b1;
							total_n        = ff_total;
							received_n     = LEN_W'(6);
							seq_n          = 4'd1;
							elapsed_n      = '0;
						end
					end
					default: begin
						cmd.op  = CMD_ERR;
						cmd.err = ERR_PCI;
					end
				endcase
			end
		end

		// Errors and a completed message both drop back to idle.
		if (cmd.op == CMD_ERR || (result && reassembling_q && cmd.data_last)) begin
			reassembling_n = 1'b0;
			total_n        = '0;
			received_n     = '0;
			seq_n          = 4'd1;
			elapsed_n      = '0;
		end
	end

	assign cmd_push = accept && result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reassembling_q <= 1'b0;
			total_q        <= '0;
			received_q     <= '0;
			seq_q          <= 4'd1;
			elapsed_q      <= '0;
		end else if (accept) begin
			reassembling_q <= reassembling_n;
			total_q        <= total_n;
			received_q     <= received_n;
			seq_q          <= seq_n;
			elapsed_q      <= elapsed_n;
		end
	end

endmodule

// File: src/itp_cmd_queue.sv
// Short command queue between the front end and the back end.
module itp_cmd_queue #(
	parameter int DEPTH = itp_pkg::CMD_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  itp_pkg::itp_cmd_t wr_cmd,
	output logic              full,
	input  logic              rd_en,
	output logic              rd_valid,
	output itp_pkg::itp_cmd_t rd_cmd
);
	import itp_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	itp_cmd_t         slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr, do_rd;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_cmd   = slots_q[rd_ptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slots_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: src/itp_back.sv
// Back end: expands queued commands into result words, one per cycle unless the output stalls.
module itp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  itp_pkg::itp_cfg_t cfg,
	input  logic              cmd_valid,
	input  itp_pkg::itp_cmd_t cmd,
	output logic              cmd_pop,
	output logic              empty,
	input  logic              pop,
	output logic [1:0]        kind,
	output logic [7:0]        value,
	output logic              last,
	output logic [2:0]        error_code,
	output logic [3:0]        fc_length
);
	import itp_pkg::*;

	logic [3:0] word_q;
	logic       out_valid_q;
	logic [1:0] kind_q;
	logic [7:0] value_q;
	logic       last_q;
	logic [2:0] err_q;
	logic [3:0] fcl_q;

	logic       load;
	logic [3:0] fclen;
	logic [3:0] nwords;
	logic [3:0] fc_idx;
	logic       end_of_cmd;
	logic [1:0] w_kind;
	logic [7:0] w_value;
	logic       w_last;
	logic [2:0] w_err;
	logic [3:0] w_fcl;

	assign fclen  = cfg.padding_enable ? FC_LEN_PADDED : FC_LEN_UNPADDED;
	assign fc_idx = word_q - FF_DATA_BYTES;

	always_comb begin
		case (cmd.op)
			CMD_ERR: nwords = 4'd1;
			CMD_FF:  nwords = FF_DATA_BYTES + fclen;
			default: nwords = {1'b0, cmd.ndata};
		endcase
	end

	assign end_of_cmd = (word_q == nwords - 1'b1);
	assign load       = cmd_valid && (!out_valid_q || pop);
	assign cmd_pop    = load && end_of_cmd;

	always_comb begin
		w_kind  = KIND_DATA;
		w_value = cmd.data[word_q[2:0]];
		w_last  = 1'b0;
		w_err   = ERR_NONE;
		w_fcl   = 4'd0;
		if (cmd.op == CMD_ERR) begin
			w_kind  = KIND_ERR;
			w_value = 8'd0;
			w_err   = cmd.err;
		end else if (word_q < {1'b0, cmd.ndata}) begin
			w_last = cmd.data_last && end_of_cmd;
		end else begin
			w_kind = KIND_FC;
			w_fcl  = fclen;
			w_last = end_of_cmd;
			case (fc_idx[2:0])
				3'd0:    w_value = FC_PCI;
				3'd1:    w_value = cfg.block_size;
				3'd2:    w_value = cfg.fc_separation_time;
				default: w_value = cfg.padding_value;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				word_q      <= end_of_cmd ? '0 : word_q + 1'b1;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q  <= w_kind;
			value_q <= w_value;
			last_q  <= w_last;
			err_q   <= w_err;
			fcl_q   <= w_fcl;
		end
	end

	assign empty      = !out_valid_q;
	assign kind       = kind_q;
	assign value      = value_q;
	assign last       = last_q;
	assign error_code = err_q;
	assign fc_length  = fcl_q;

endmodule

// File: src/isotp_receive_reassembler.sv
// Top level of the ISO-TP receive reassembler: configuration and wiring.
//
// Channel    Direction  Handshake             Word
// input      in         push / full           mode, frame_id, frame_byte0..7
// result     out        empty / pop           kind, value, last, error_code, fc_length
// config     in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// The front end takes one frame or tick in every cycle while the command queue
// has room; its reassembly state is updated in that same cycle. The back end
// drives one result word per cycle, while the result side does not stall, from
// the head of the queue into the output register; a frame yields 1 to 14 words,
// a first frame with padded flow control being the longest.
// A frame or tick that yields nothing never enters the queue. Either side may
// stall freely; the queue and the output register absorb the difference.
// Reset clears the reassembly state, empties the queue and the output register and
// loads the configuration defaults. The configuration port is always ready.
module isotp_receive_reassembler #(
	parameter int CMD_DEPTH = itp_pkg::CMD_DEPTH
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic                     mode,
	input  logic [28:0]              frame_id,
	input  logic [7:0]               frame_byte0,
	input  logic [7:0]               frame_byte1,
	input  logic [7:0]               frame_byte2,
	input  logic [7:0]               frame_byte3,
	input  logic [7:0]               frame_byte4,
	input  logic [7:0]               frame_byte5,
	input  logic [7:0]               frame_byte6,
	input  logic [7:0]               frame_byte7,
	output logic                     empty,
	input  logic                     pop,
	output logic [1:0]               kind,
	output logic [7:0]               value,
	output logic                     last,
	output logic [2:0]               error_code,
	output logic [3:0]               fc_length,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [itp_pkg::IDX_W-1:0] cfg_index,
	input  logic [itp_pkg::CFG_W-1:0] cfg_data
);
	import itp_pkg::*;

	itp_cfg_t        cfg_q;
	logic [7:0][7:0] frame_bytes;
	logic            cmd_push;
	itp_cmd_t        front_cmd;
	logic            q_full;
	logic            q_valid;
	logic            q_pop;
	itp_cmd_t        head_cmd;

	assign cfg_ready = 1'b1;
	assign full      = q_full;

	assign frame_bytes = {frame_byte7, frame_byte6, frame_byte5, frame_byte4,
	                      frame_byte3, frame_byte2, frame_byte1, frame_byte0};

	// Register writes; an index past the last register is accepted and dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.receive_id         <= '0;
			cfg_q.block_size         <= '0;
			cfg_q.fc_separation_time <= '0;
			cfg_q.timeout_limit_ms   <= TIMEOUT_RESET;
			cfg_q.padding_enable     <= 1'b1;
			cfg_q.padding_value      <= PADDING_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_RECEIVE_ID:    cfg_q.receive_id         <= cfg_data[ID_W-1:0];
				REG_FC_BLOCK_SIZE: cfg_q.block_size         <= cfg_data[7:0];
				REG_FC_SEP_TIME:   cfg_q.fc_separation_time <= cfg_data[7:0];
				REG_TIMEOUT_LIMIT: cfg_q.timeout_limit_ms   <= cfg_data[TIMER_W-1:0];
				REG_PADDING_EN:    cfg_q.padding_enable     <= cfg_data[0];
				REG_PADDING_VALUE: cfg_q.padding_value      <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	itp_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.push        (push),
		.q_full      (q_full),
		.mode        (mode),
		.frame_id    (frame_id),
		.frame_bytes (frame_bytes),
		.cmd_push    (cmd_push),
		.cmd         (front_cmd)
	);

	itp_cmd_queue #(
		.DEPTH (CMD_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cmd_push),
		.wr_cmd   (front_cmd),
		.full     (q_full),
		.rd_en    (q_pop),
		.rd_valid (q_valid),
		.rd_cmd   (head_cmd)
	);

	itp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.cmd_valid  (q_valid),
		.cmd        (head_cmd),
		.cmd_pop    (q_pop),
		.empty      (empty),
		.pop        (pop),
		.kind       (kind),
		.value      (value),
		.last       (last),
		.error_code (error_code),
		.fc_length  (fc_length)
	);

endmodule

// File: src/itp_checker.sv
// Port-level checks of the reassembler's result words, bound to the top level.
module itp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [1:0] kind,
	input logic [7:0] value,
	input logic       last,
	input logic [2:0] error_code,
	input logic [3:0] fc_length
);
	import itp_pkg::*;

	// An error word carries a real code and nothing else.
	a_err_word: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == KIND_ERR) |->
		(value == 8'd0 && !last && fc_length == 4'd0 &&
		 error_code != ERR_NONE && error_code <= ERR_TIMEOUT))
		else $error("malformed error word");

	// Payload words carry no error code and no flow control length.
	a_data_word: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == KIND_DATA) |-> (error_code == ERR_NONE && fc_length == 4'd0))
		else $error("malformed payload word");

	// Flow control words carry no error code and name a legal frame length.
	a_fc_word: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == KIND_FC) |->
		(error_code == ERR_NONE &&
		 (fc_length == FC_LEN_PADDED || fc_length == FC_LEN_UNPADDED)))
		else $error("malformed flow control word");

	// A waiting word is held until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(kind) && $stable(value) && $stable(last)))
		else $error("result word changed while stalled");

endmodule

bind isotp_receive_reassembler itp_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.empty      (empty),
	.pop        (pop),
	.kind       (kind),
	.value      (value),
	.last       (last),
	.error_code (error_code),
	.fc_length  (fc_length)
);
